[rtl/core/circular_deque_top_macros.svh]
// ----------------------------------------------------------------------------
// circular_deque_top_macros
// Assertion macros shared by the deque RTL. Each macro expects a clock named
// clk and an active-low asynchronous reset named arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int WORD_W    = 32;
	localparam int FUNC_W    = 3;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd4;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [WORD_W-1:0] push_value;
	} deque_req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
	} deque_rsp_t;

endpackage

[rtl/core/cdq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/circular_deque_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of signed words held in a ring of DEPTH slots.
//
//   Channel  Valid      Stall      Payload  Direction
//   request  req_valid  req_stall  req      into the block
//   response rsp_valid  rsp_stall  rsp      out of the block
//
// Each request steps through S_IDLE, S_READ and S_LOAD: the pointers update
// and the push word is written on acceptance, the two ring copies are read at
// head and tail in S_READ, and the response register loads in S_LOAD.
// Two identical ring copies give one read port for the front and one for
// the rear. The ring needs no clearing after reset; only pointers and flags
// reset. A stalled response holds its register; the next request is taken
// as soon as the response has been loaded.
// ----------------------------------------------------------------------------
`include "circular_deque_top_macros.svh"

module circular_deque_top import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  deque_req_t req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output deque_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		idx_inc = (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		idx_dec = (i == '0) ? LAST : i - 1'b1;
	endfunction

	state_t state_q, state_d;
	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic empty_q, empty_d;
	status_t status_q, status_d;
	logic full_w;
	logic accept;
	logic load_rsp;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [WORD_W-1:0] front_rd, rear_rd;
	logic rsp_valid_q;
	deque_rsp_t rsp_q;

	assign accept = req_valid && !req_stall;
	assign full_w = !empty_q && (idx_inc(tail_q) == head_q);

	// Pointer update and ring write for the request being accepted.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		status_d = ST_DONE;
		wr_en    = 1'b0;
		wr_addr  = '0;
		case (req.func)
			FN_PUSH_FRONT, FN_PUSH_REAR: begin
				if (full_w) begin
					status_d = ST_OVERFLOW;
				end else if (empty_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
					wr_en   = 1'b1;
				end else if (req.func == FN_PUSH_FRONT) begin
					head_d  = idx_dec(head_q);
					wr_addr = head_d;
					wr_en   = 1'b1;
				end else begin
					tail_d  = idx_inc(tail_q);
					wr_addr = tail_d;
					wr_en   = 1'b1;
				end
			end
			FN_POP_FRONT, FN_POP_REAR: begin
				if (empty_q) begin
					status_d = ST_UNDERFLOW;
				end else if (head_q == tail_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else if (req.func == FN_POP_FRONT) begin
					head_d = idx_inc(head_q);
				end else begin
					tail_d = idx_dec(tail_q);
				end
			end
			FN_QUERY: begin
				status_d = ST_DONE;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	cdq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ring_front (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (wr_addr),
		.wdata (req.push_value),
		.raddr (head_q),
		.rdata (front_rd)
	);

	cdq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ring_rear (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (wr_addr),
		.wdata (req.push_value),
		.raddr (tail_q),
		.rdata (rear_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		req_stall = 1'b1;
		load_rsp  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
			end
			S_READ: begin
				req_stall = 1'b1;
			end
			S_LOAD: begin
				load_rsp = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status      <= status_q;
			rsp_q.front_value <= empty_q ? '1 : front_rd;
			rsp_q.rear_value  <= empty_q ? '1 : rear_rd;
			rsp_q.is_empty    <= empty_q;
			rsp_q.is_full     <= full_w;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CDQ_ASSERT_SAME(a_empty_ptrs_zero, empty_q, (head_q == '0) && (tail_q == '0), "empty deque with nonzero pointers")
	`CDQ_ASSERT_NEXT(a_pop_underflow, accept && empty_q && ((req.func == FN_POP_FRONT) || (req.func == FN_POP_REAR)), (status_q == ST_UNDERFLOW) && empty_q, "pop from empty deque not refused")
	`CDQ_ASSERT_SAME(a_empty_rsp_words, rsp_valid_q && rsp_q.is_empty, (rsp_q.front_value == '1) && (rsp_q.rear_value == '1) && !rsp_q.is_full, "empty response with bad words or full flag")
	`CDQ_ASSERT_NEXT(a_full_refuses_push, accept && full_w && ((req.func == FN_PUSH_FRONT) || (req.func == FN_PUSH_REAR)), (status_q == ST_OVERFLOW) && $stable(head_q) && $stable(tail_q), "push into full deque changed pointers")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_deque_top. A mirror of the ring, its head
// and tail and its empty flag predicts the response to every accepted
// request. A directed pass covers the empty and full corners, followed by
// fill and drain bursts with random words. Both sides idle at random, and
// one long response hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;
	import cdq_pkg::*;

	class deque_mirror;
		logic signed [WORD_W-1:0] ring [DEPTH_DEF];
		int unsigned              head;
		int unsigned              tail;
		bit                       empty;
		deque_rsp_t               expected_rsps [$];
		int                       errors;

		function new();
			head   = 0;
			tail   = 0;
			empty  = 1'b1;
			errors = 0;
		endfunction

		function int unsigned next_slot(int unsigned i);
			return (i + 1 >= DEPTH_DEF) ? 0 : i + 1;
		endfunction

		function int unsigned prev_slot(int unsigned i);
			return (i == 0) ? DEPTH_DEF - 1 : i - 1;
		endfunction

		function bit full_now();
			return !empty && next_slot(tail) == head;
		endfunction

		function void note_request(deque_req_t r);
			deque_rsp_t e;
			e.status = ST_DONE;
			case (r.func)
				FN_PUSH_FRONT, FN_PUSH_REAR: begin
					if (full_now()) begin
						e.status = ST_OVERFLOW;
					end else if (empty) begin
						// A push into an empty deque always restarts at slot zero.
						head    = 0;
						tail    = 0;
						ring[0] = r.push_value;
						empty   = 1'b0;
					end else if (r.func == FN_PUSH_FRONT) begin
						head       = prev_slot(head);
						ring[head] = r.push_value;
					end else begin
						tail       = next_slot(tail);
						ring[tail] = r.push_value;
					end
				end
				FN_POP_FRONT, FN_POP_REAR: begin
					if (empty) begin
						e.status = ST_UNDERFLOW;
					end else if (head == tail) begin
						head  = 0;
						tail  = 0;
						empty = 1'b1;
					end else if (r.func == FN_POP_FRONT) begin
						head = next_slot(head);
					end else begin
						tail = prev_slot(tail);
					end
				end
				default: begin
				end
			endcase
			e.front_value = empty ? '1 : ring[head];
			e.rear_value  = empty ? '1 : ring[tail];
			e.is_empty    = empty;
			e.is_full     = full_now();
			expected_rsps.push_back(e);
		endfunction

		function void compare_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_response(deque_rsp_t got);
			deque_rsp_t e;
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %p", $time, got);
				errors++;
				return;
			end
			e = expected_rsps.pop_front();
			compare_field("status", e.status, got.status);
			compare_field("front_value", e.front_value, got.front_value);
			compare_field("rear_value", e.rear_value, got.rear_value);
			compare_field("is_empty", e.is_empty, got.is_empty);
			compare_field("is_full", e.is_full, got.is_full);
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	deque_req_t req       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	deque_rsp_t rsp;

	deque_mirror mirror = new();
	bit          idle_on      = 1'b0;
	bit          hold_off_req = 1'b0;

	always #6 clk = ~clk;

	circular_deque_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Both channels are sampled at the edge, before any update of that edge lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				mirror.check_response(rsp);
			if (req_valid && !req_stall)
				mirror.note_request(req);
		end
	end

	task automatic send_request(input logic [FUNC_W-1:0] f,
		input logic signed [WORD_W-1:0] v);
		deque_req_t r;
		int         gap;
		int         pick;
		r.func       = f;
		r.push_value = v;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		gap = 0;
		if (idle_on) begin
			pick = $urandom_range(0, 99);
			if (pick >= 95)
				gap = $urandom_range(10, 30);
			else if (pick >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [WORD_W-1:0] random_word();
		case ($urandom_range(0, 19))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin : rsp_stall_gen
		int run;
		bit level;
		run   = 0;
		level = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				level        = 1'b1;
				run          = 80;
			end else if (run == 0) begin
				if (!idle_on || $urandom_range(0, 1)) begin
					level = 1'b0;
					run   = $urandom_range(1, 20);
				end else begin
					level = 1'b1;
					run   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
						: $urandom_range(10, 30);
				end
			end
			run--;
			rsp_stall <= level;
		end
	end

	initial begin : stimulus
		logic [FUNC_W-1:0] f;
		bit                filling;
		int                burst;
		int                pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners: underflow on empty, fill to full, overflow, spare codes, drain.
		send_request(FN_QUERY, 32'h1234_5678);
		send_request(FN_POP_FRONT, '0);
		send_request(FN_POP_REAR, '0);
		send_request(FN_PUSH_FRONT, 32'h7fff_ffff);
		send_request(FN_PUSH_REAR, 32'h8000_0000);
		send_request(FN_PUSH_FRONT, '1);
		send_request(FN_PUSH_REAR, '0);
		send_request(FN_PUSH_FRONT, 32'h5555_5555);
		send_request(FN_PUSH_REAR, 32'haaaa_aaaa);
		send_request(FN_PUSH_FRONT, 32'h0000_0001);
		send_request(FN_PUSH_REAR, 32'hffff_fffe);
		send_request(FN_PUSH_FRONT, 32'h0bad_f00d);
		send_request(FN_PUSH_REAR, 32'h0bad_f00d);
		send_request(3'd5, '1);
		send_request(3'd6, '0);
		send_request(3'd7, '1);
		repeat (4) begin
			send_request(FN_POP_FRONT, '0);
			send_request(FN_POP_REAR, '0);
		end

		// Fill and drain bursts keep the deque moving between empty and full.
		idle_on = 1'b1;
		filling = 1'b1;
		burst   = 0;
		for (int k = 0; k < 400; k++) begin
			if (k == 100)
				idle_on = 1'b0;
			if (k == 150)
				hold_off_req = 1'b1;
			if (k == 200)
				idle_on = 1'b1;
			if (burst == 0) begin
				filling = ~filling;
				burst   = $urandom_range(5, 20);
			end
			burst--;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				f = (pick < 5) ? FN_QUERY : 3'($urandom_range(5, 7));
			else if ((pick < 75) == filling)
				f = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_REAR;
			else
				f = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_REAR;
			send_request(f, random_word());
		end
		req_valid <= 1'b0;
		idle_on = 1'b0;

		while (mirror.expected_rsps.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mirror.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

[circular_deque_top.f]
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/circular_deque_top.sv
verif/testbench.sv
